// ===== hdl/bse_pkg.sv =====
// Shared types and constants for the bubble sort engine.
// Used by bse_cell and bubble_sort_engine; depends on nothing else.
`default_nettype none

package bse_pkg;

    localparam int KEY_W        = 16;
    localparam int NUM_KEYS_DEF = 8;

    // Sequencer states: collect keys, run the transposition phases, send the run.
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } bse_state_t;

    // Per-cell control: write the input key, take the left or the right neighbor's key.
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } bse_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/bse_cell.sv =====
// One cell of the sorting row: a key register and a compare against the right neighbor.
// Depends on bse_pkg for the key width and the cell control struct.
`default_nettype none

module bse_cell
    import bse_pkg::*;
(
    input  wire logic                 clk,
    input  wire bse_cell_ctrl_t       ctrl,
    input  wire logic [KEY_W-1:0]     load_key,
    input  wire logic [KEY_W-1:0]     left_key,
    input  wire logic [KEY_W-1:0]     right_key,
    output logic      [KEY_W-1:0]     key,
    output logic                      gt_right
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            key_next = load_key;
        end
        else if (ctrl.take_right)
        begin
            key_next = right_key;
        end
        else if (ctrl.take_left)
        begin
            key_next = left_key;
        end
        else
        begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key      = key_reg;
    // Only a strictly greater left key is swapped, so equal keys stay put.
    assign gt_right = (key_reg > right_key);

endmodule

`default_nettype wire

// ===== hdl/bubble_sort_engine.sv =====
// Top level of the bubble sort engine: sequencer and a row of NUM_KEYS sorting cells.
// Depends on bse_pkg and bse_cell.
//
// Usage:
//   Input channel (load_valid / load_stall): one key per item, with final_item
//   marking the last key of a run. A run also ends on the item that fills the row.
//   Output channel (sort_valid / sort_stall): the run's keys in ascending order,
//   one per item, run_end set on the last one.
//   Sequence for a run of n keys: the n keys are loaded, then the cell row runs
//   odd-even transposition phases (in each phase the pairs of that phase's parity
//   compare and swap in parallel), then the n results are sent as the receiver
//   takes them. sort_valid rises when the last transposition phase is done.
//   load_stall is high from the end of a run until its last result is taken.
//   A stall on the output holds the current result and freezes the row.
//   Reset empties the run and returns to loading; key registers are not cleared.
`default_nettype none

module bubble_sort_engine
    import bse_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               load_valid,
    output logic                    load_stall,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic               final_item,
    output logic                    sort_valid,
    input  wire logic               sort_stall,
    output logic      [KEY_W-1:0]   sorted_key,
    output logic                    run_end
);

    localparam int CNT_W   = $clog2(NUM_KEYS + 1);
    localparam int PHASE_W = $clog2(NUM_KEYS);

    bse_state_t         state_reg;
    bse_state_t         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;

    logic               load_take;
    logic               emit_take;
    logic               run_done;
    logic               sort_done;

    logic [KEY_W-1:0]   cell_key  [NUM_KEYS];
    logic               cell_gt   [NUM_KEYS];
    logic               pair_swap [NUM_KEYS];
    bse_cell_ctrl_t     cell_ctrl [NUM_KEYS];

    assign load_take = load_valid && !load_stall;
    assign emit_take = sort_valid && !sort_stall;
    assign run_done  = final_item || (count_reg == CNT_W'(NUM_KEYS - 1));
    assign sort_done = (phase_reg == PHASE_W'(NUM_KEYS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (load_take && run_done)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (sort_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_take && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Outputs and counters.
    always_comb
    begin
        load_stall = 1'b1;
        sort_valid = 1'b0;
        count_next = count_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                load_stall = 1'b0;
                phase_next = '0;
                if (load_take)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_SORT:
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
            ST_EMIT:
            begin
                sort_valid = 1'b1;
                if (emit_take)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                load_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_KEYS; gi++)
        begin : g_cell
            logic [KEY_W-1:0] left_key;
            logic [KEY_W-1:0] right_key;
            logic             from_left;

            // Pair (gi, gi+1) works on phases of its own parity and only inside the run.
            if (gi < NUM_KEYS - 1)
            begin : g_pair
                assign pair_swap[gi] = (state_reg == ST_SORT)
                                    && (phase_reg[0] == ((gi % 2) == 1))
                                    && (count_reg > CNT_W'(gi + 1))
                                    && cell_gt[gi];
                assign right_key     = cell_key[gi + 1];
            end
            else
            begin : g_last
                assign pair_swap[gi] = 1'b0;
                assign right_key     = '0;
            end

            if (gi > 0)
            begin : g_left
                assign left_key  = cell_key[gi - 1];
                assign from_left = pair_swap[gi - 1];
            end
            else
            begin : g_first
                assign left_key  = '0;
                assign from_left = 1'b0;
            end

            // During output the row shifts toward cell 0 on every taken item.
            assign cell_ctrl[gi].load       = load_take && (count_reg == CNT_W'(gi));
            assign cell_ctrl[gi].take_right = emit_take || pair_swap[gi];
            assign cell_ctrl[gi].take_left  = from_left;

            bse_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[gi]),
                .load_key  (key),
                .left_key  (left_key),
                .right_key (right_key),
                .key       (cell_key[gi]),
                .gt_right  (cell_gt[gi])
            );
        end
    endgenerate

    assign sorted_key = cell_key[0];
    assign run_end    = (count_reg == CNT_W'(1));

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (count_reg != '0))
        else $error("output phase entered with an empty run");

    a_emit_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && (count_reg > CNT_W'(1))) |-> (cell_key[0] <= cell_key[1]))
        else $error("row front is out of order during output");

    a_emit_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && ($past(state_reg) != ST_EMIT))
            |-> ($past(state_reg) == ST_SORT))
        else $error("output started without a sort");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_W'(NUM_KEYS)))
        else $error("run count exceeds the row length");

endmodule

`default_nettype wire
